@@ src/bbc_pkg.sv @@
// package for the lru block buffer cache
// holds slot count, field widths and command / result codes; no dependencies
package bbc_pkg;

    localparam int NUM_SLOTS  = 16;
    localparam int SLOT_W     = $clog2(NUM_SLOTS);
    localparam int DEV_W      = 8;
    localparam int SEC_W      = 48;
    localparam int TAG_W      = DEV_W + SEC_W;

    localparam logic [1:0] CMD_FETCH = 2'd0;
    localparam logic [1:0] CMD_DIRTY = 2'd1;
    localparam logic [1:0] CMD_FLUSH = 2'd2;

    localparam logic [1:0] RES_HIT   = 2'd0;
    localparam logic [1:0] RES_READ  = 2'd1;
    localparam logic [1:0] RES_WBACK = 2'd2;
    localparam logic [1:0] RES_DONE  = 2'd3;

    typedef logic [SLOT_W-1:0] slot_t;

endpackage

@@ src/block_buffer_cache_lru.sv @@
// top level of the lru block buffer cache
// tags live in a synchronous memory; valid, dirty and rank are flip-flops; uses bbc_pkg
//
//  channel  dir  tdata fields (low bit up)                           tuser / tlast
//  s_axis   in   command[1:0] device_id[9:2] sector_number[57:10]     -
//                dirty_slot[61:58], zero fill to 64
//  m_axis   out  result_kind[1:0] buffer_slot[5:2] request_device     tlast = last_result
//                [13:6] request_sector[61:14], zero fill to 64
//
// fetch: one priming read, then the slots in order; a hit answers when its slot is read, and a miss
// scans every slot, reads the victim tag in the miss state, then sends one or two result words.
// flush: a scan of every slot, a writeback word per dirty slot, then done. mark dirty is done in
// the idle state. reset clears valid and dirty and sets the rank table to rank i for slot i at
// once; tags need no clearing. a stall on m_axis holds the scan; one word waits in the output
// register.
module block_buffer_cache_lru (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // command, device_id, sector_number, dirty_slot
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // result_kind, buffer_slot, request_device, request_sector
    output logic        m_axis_tlast
);
    import bbc_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_MISS  = 3'd2;
    localparam logic [2:0] ST_FILL  = 3'd3;
    localparam logic [2:0] ST_FLUSH = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [TAG_W-1:0]     tag_mem [NUM_SLOTS];
    logic [TAG_W-1:0]     rd_data_reg;
    logic [NUM_SLOTS-1:0] valid_reg, dirty_reg;
    slot_t                rank_reg [NUM_SLOTS];

    logic [2:0]           state_reg;
    logic [SLOT_W:0]      idx_reg;       // slot being presented by the memory read
    logic                 rd_ok_reg;     // rd_data_reg holds slot idx_reg-1
    logic [1:0]           cmd_reg;
    logic [TAG_W-1:0]     tag_reg;
    slot_t                victim_reg;

    logic                 ov_reg;
    logic [63:0]          od_reg;
    logic                 ol_reg;

    logic [1:0]  in_cmd;
    logic [TAG_W-1:0] in_tag;
    slot_t       in_ds;
    assign in_cmd = s_axis_tdata[1:0];
    assign in_tag = s_axis_tdata[57:2];
    assign in_ds  = s_axis_tdata[58 +: SLOT_W];

    logic out_free;
    assign out_free = !ov_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;
    assign m_axis_tlast  = ol_reg;

    slot_t cur;                          // slot held by rd_data_reg
    assign cur = slot_t'(idx_reg - 1'b1);

    logic scan_hit, scan_wb, out_load, rd_en;
    assign scan_hit = (state_reg == ST_SCAN) && rd_ok_reg && (cmd_reg == CMD_FETCH)
                      && valid_reg[cur] && (rd_data_reg == tag_reg);
    assign scan_wb  = (state_reg == ST_SCAN) && rd_ok_reg && (cmd_reg == CMD_FLUSH)
                      && valid_reg[cur] && dirty_reg[cur];
    assign out_load = out_free && (scan_hit || scan_wb || state_reg == ST_FILL
                      || state_reg == ST_FLUSH || state_reg == ST_DONE);
    // a stalled scan keeps the word for slot idx_reg-1
    assign rd_en = (state_reg != ST_SCAN) || out_free;

    logic victim_sel;                    // lowest rank is always rank 0
    slot_t lru_slot;
    always_comb
    begin
        lru_slot = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
            if (rank_reg[i] == '0)
                lru_slot = slot_t'(i);
        victim_sel = 1'b1;
    end

    function automatic logic [63:0] pack(logic [1:0] k, slot_t s, logic [TAG_W-1:0] t);
        logic [63:0] w;
        w = '0;
        w[1:0] = k;
        w[2 +: SLOT_W] = s;
        w[6 +: TAG_W] = t;
        return w;
    endfunction

    logic          mk_en;
    slot_t         mk_slot;
    always_comb
    begin
        mk_en = 1'b0;
        mk_slot = cur;
        if (scan_hit && out_free)
            mk_en = 1'b1;
        if (state_reg == ST_FILL && out_free)
        begin
            mk_en = 1'b1;
            mk_slot = victim_reg;
        end
    end

    logic tag_we;
    assign tag_we = (state_reg == ST_FILL) && out_free;

    always_ff @(posedge clk)
    begin
        if (tag_we)
            tag_mem[victim_reg] <= tag_reg;
        if (rd_en)
            rd_data_reg <= tag_mem[slot_t'(idx_reg)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            idx_reg    <= '0;
            rd_ok_reg  <= 1'b0;
            valid_reg  <= '0;
            dirty_reg  <= '0;
            ov_reg     <= 1'b0;
            od_reg     <= '0;
            ol_reg     <= 1'b0;
            cmd_reg    <= CMD_FETCH;
            tag_reg    <= '0;
            victim_reg <= '0;
            for (int i = 0; i < NUM_SLOTS; i++)
                rank_reg[i] <= slot_t'(i);
        end
        else
        begin
            if (out_load)
                ov_reg <= 1'b1;
            else if (ov_reg && m_axis_tready)
                ov_reg <= 1'b0;
            if (mk_en)
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                    if (rank_reg[i] > rank_reg[mk_slot])
                        rank_reg[i] <= rank_reg[i] - 1'b1;
                rank_reg[mk_slot] <= slot_t'(NUM_SLOTS - 1);
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    idx_reg   <= '0;
                    rd_ok_reg <= 1'b0;
                    if (s_axis_tvalid)
                    begin
                        cmd_reg <= in_cmd;
                        tag_reg <= in_tag;
                        if (in_cmd == CMD_FETCH || in_cmd == CMD_FLUSH)
                            state_reg <= ST_SCAN;
                        else if (in_cmd == CMD_DIRTY && valid_reg[in_ds])
                            dirty_reg[in_ds] <= 1'b1;
                    end
                end
                ST_SCAN:
                begin
                    if (out_free)
                    begin
                        rd_ok_reg <= 1'b1;
                        if (scan_hit)
                        begin
                            od_reg <= pack(RES_HIT, cur, tag_reg);
                            ol_reg <= 1'b1;
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            if (scan_wb)
                            begin
                                od_reg <= pack(RES_WBACK, cur, rd_data_reg);
                                ol_reg <= 1'b0;
                            end
                            if (idx_reg == (SLOT_W+1)'(NUM_SLOTS))
                            begin
                                state_reg <= (cmd_reg == CMD_FETCH) ? ST_MISS : ST_DONE;
                                victim_reg <= lru_slot;
                                idx_reg <= {1'b0, lru_slot};
                            end
                            else
                                idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                ST_MISS:
                    state_reg <= ST_FILL;    // victim tag read lands in rd_data_reg
                ST_FILL:
                begin
                    if (out_free)
                    begin
                        if (valid_reg[victim_reg] && dirty_reg[victim_reg])
                        begin
                            od_reg <= pack(RES_WBACK, victim_reg, rd_data_reg);
                            ol_reg <= 1'b0;
                            state_reg <= ST_FLUSH;
                        end
                        else
                        begin
                            od_reg <= pack(RES_READ, victim_reg, tag_reg);
                            ol_reg <= 1'b1;
                            state_reg <= ST_IDLE;
                        end
                        valid_reg[victim_reg] <= 1'b1;
                        dirty_reg[victim_reg] <= 1'b0;
                    end
                end
                ST_FLUSH:
                begin
                    // read request after a victim writeback
                    if (out_free)
                    begin
                        od_reg <= pack(RES_READ, victim_reg, tag_reg);
                        ol_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        od_reg <= pack(RES_DONE, slot_t'(0), '0);
                        ol_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_axis_tready)
        else $error("ready while busy");
    a_mru_top: assert property (@(posedge clk) disable iff (!rst_n)
        mk_en |=> (rank_reg[$past(mk_slot)] == slot_t'(NUM_SLOTS - 1)))
        else $error("touched slot not most recent");
    a_fill_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL && out_free) |=> valid_reg[$past(victim_reg)])
        else $error("filled slot not valid");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !m_axis_tready) |=> $stable(od_reg) && ov_reg)
        else $error("output word changed while stalled");
    a_victim_lru: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MISS) |-> (rank_reg[victim_reg] == '0) && victim_sel)
        else $error("victim not least recent");

endmodule

@@ sim/tb_block_buffer_cache_lru.sv @@
// testbench for the lru block buffer cache: directed and random fetch, mark-dirty, flush and unknown
// command words, predicted by a cache model in the scoreboard class; depends on bbc_pkg and the rtl
module tb_block_buffer_cache_lru;
    import bbc_pkg::*;

    typedef struct packed {
        logic [1:0]       kind;
        logic [SLOT_W-1:0] slot;
        logic [DEV_W-1:0] dev;
        logic [SEC_W-1:0] sec;
        logic             last;
    } cache_res_t;

    class cache_scoreboard;
        logic             valid_q [NUM_SLOTS];
        logic             dirty_q [NUM_SLOTS];
        logic [DEV_W-1:0] dev_q [NUM_SLOTS];
        logic [SEC_W-1:0] sec_q [NUM_SLOTS];
        int               rank_q [NUM_SLOTS];
        cache_res_t       pending_q [$];
        bit               failed;

        function new();
            failed = 0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                valid_q[i] = 0;
                dirty_q[i] = 0;
                dev_q[i] = '0;
                sec_q[i] = '0;
                rank_q[i] = i;
            end
        endfunction

        function void push(logic [1:0] k, int s, logic [DEV_W-1:0] d,
                           logic [SEC_W-1:0] c, logic l);
            cache_res_t r;
            r.kind = k;
            r.slot = s[SLOT_W-1:0];
            r.dev = d;
            r.sec = c;
            r.last = l;
            pending_q.push_back(r);
        endfunction

        function void touch(int s);
            int r;
            r = rank_q[s];
            for (int i = 0; i < NUM_SLOTS; i++)
                if (rank_q[i] > r)
                    rank_q[i]--;
            rank_q[s] = NUM_SLOTS - 1;
        endfunction

        function void note_input(logic [1:0] cmd, logic [DEV_W-1:0] d,
                                 logic [SEC_W-1:0] c, logic [3:0] ds);
            int victim;
            victim = 0;
            if (cmd == CMD_FETCH)
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                    if (valid_q[i] && dev_q[i] == d && sec_q[i] == c)
                    begin
                        touch(i);
                        push(RES_HIT, i, d, c, 1'b1);
                        return;
                    end
                for (int i = 1; i < NUM_SLOTS; i++)
                    if (rank_q[i] < rank_q[victim])
                        victim = i;
                if (valid_q[victim] && dirty_q[victim])
                    push(RES_WBACK, victim, dev_q[victim], sec_q[victim], 1'b0);
                dev_q[victim] = d;
                sec_q[victim] = c;
                valid_q[victim] = 1;
                dirty_q[victim] = 0;
                touch(victim);
                push(RES_READ, victim, d, c, 1'b1);
            end
            else if (cmd == CMD_DIRTY)
            begin
                if (ds < NUM_SLOTS && valid_q[ds])
                    dirty_q[ds] = 1;
            end
            else if (cmd == CMD_FLUSH)
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                    if (valid_q[i] && dirty_q[i])
                        push(RES_WBACK, i, dev_q[i], sec_q[i], 1'b0);
                push(RES_DONE, 0, '0, '0, 1'b1);
            end
        endfunction

        function void check_result(logic [63:0] data, logic last);
            cache_res_t e;
            if (pending_q.size() == 0)
            begin
                $error("unexpected result word %h", data);
                failed = 1;
                return;
            end
            e = pending_q.pop_front();
            if (data[1:0] != e.kind)
            begin
                $error("result_kind exp %0d got %0d", e.kind, data[1:0]);
                failed = 1;
            end
            if (data[5:2] != e.slot)
            begin
                $error("buffer_slot exp %0d got %0d", e.slot, data[5:2]);
                failed = 1;
            end
            if (data[13:6] != e.dev)
            begin
                $error("request_device exp %h got %h", e.dev, data[13:6]);
                failed = 1;
            end
            if (data[61:14] != e.sec)
            begin
                $error("request_sector exp %h got %h", e.sec, data[61:14]);
                failed = 1;
            end
            if (data[63:62] != 2'b00)
            begin
                $error("tdata fill exp 0 got %0d", data[63:62]);
                failed = 1;
            end
            if (last != e.last)
            begin
                $error("last_result exp %0d got %0d", e.last, last);
                failed = 1;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tlast;

    cache_scoreboard sb;
    bit              stall_en;
    int              stall_cnt;
    logic [DEV_W-1:0] used_dev [$];
    logic [SEC_W-1:0] used_sec [$];

    block_buffer_cache_lru dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // valid stays high into the next word when there is no gap
    task automatic send_word(logic [1:0] cmd, logic [DEV_W-1:0] d,
                             logic [SEC_W-1:0] c, logic [3:0] ds);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        s_axis_tdata <= {2'b00, ds, c, d, cmd};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_input(cmd, d, c, ds);
        used_dev.push_back(d);
        used_sec.push_back(c);
        @(negedge clk);
    endtask

    task automatic send_fetch_random();
        int k;
        logic [DEV_W-1:0] d;
        logic [SEC_W-1:0] c;
        // mostly reuse recent tags so hits and dirty evictions happen
        if (used_dev.size() > 0 && $urandom_range(0, 99) < 55)
        begin
            k = $urandom_range(0, used_dev.size() - 1);
            if (used_dev.size() > 24)
                k = $urandom_range(used_dev.size() - 24, used_dev.size() - 1);
            send_word(CMD_FETCH, used_dev[k], used_sec[k], 4'($urandom));
        end
        else
        begin
            d = 8'($urandom);
            c = {16'($urandom), 32'($urandom)};
            send_word(CMD_FETCH, d, c, 4'($urandom));
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        // a trailing mark-dirty may still be in flight
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    // receiver with random stalls, now and then a long one
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            stall_cnt = 0;
            m_axis_tready <= 1'b0;
        end
        else if (!stall_en)
            m_axis_tready <= 1'b1;
        else if (stall_cnt > 0)
        begin
            stall_cnt = stall_cnt - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if ($urandom_range(0, 99) < 70)
                m_axis_tready <= 1'b1;
            else
            begin
                if ($urandom_range(0, 99) < 12)
                    stall_cnt = $urandom_range(8, 40);
                m_axis_tready <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tlast);
    end

    initial
    begin
        int p;
        sb = new();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        stall_en = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty flush, extremes, mark-dirty of invalid and valid slots, unknown cmd
        send_word(CMD_FLUSH, 8'hff, '1, 4'hf);
        send_word(CMD_DIRTY, 8'h00, '0, 4'd3);
        send_word(CMD_FETCH, 8'h00, '0, 4'h0);
        send_word(CMD_FETCH, 8'hff, '1, 4'hf);
        send_word(CMD_FETCH, 8'h00, '0, 4'h0);
        send_word(CMD_DIRTY, 8'h00, '0, 4'd0);
        send_word(CMD_DIRTY, 8'h00, '0, 4'd1);
        send_word(2'd3, 8'haa, 48'h5555_5555_5555, 4'ha);
        send_word(CMD_FLUSH, 8'h00, '0, 4'h0);
        for (int i = 0; i < 16; i++)
            send_word(CMD_FETCH, 8'(i + 1), 48'(i * 977), 4'(i));
        send_word(CMD_FLUSH, 8'h00, '0, 4'h0);

        // pause until all results are back
        wait_drained();
        stall_en = 1'b1;

        for (int n = 0; n < 250; n++)
        begin
            p = $urandom_range(0, 99);
            if (p < 60)
                send_fetch_random();
            else if (p < 85)
                send_word(CMD_DIRTY, 8'($urandom), {16'($urandom), 32'($urandom)},
                          4'($urandom));
            else if (p < 95)
                send_word(CMD_FLUSH, 8'($urandom), {16'($urandom), 32'($urandom)},
                          4'($urandom));
            else
                send_word(2'd3, 8'($urandom), {16'($urandom), 32'($urandom)},
                          4'($urandom));
            if (n == 120)
                wait_drained();
            if (n == 180)
                stall_en = 1'b0;
            if (n == 220)
                stall_en = 1'b1;
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (!sb.failed)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #40000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ block_buffer_cache_lru.f @@
src/bbc_pkg.sv
src/block_buffer_cache_lru.sv
sim/tb_block_buffer_cache_lru.sv
